// ----- rtl/core/bcpm_pkg.sv -----
// Shared types and constants for the balance cascade controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bcpm_pkg;

    // Serial multiplier: signed multiplicand times unsigned multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Serial divider dividend width (ramp product magnitude)
    localparam int DIV_W = 40;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Configuration register indices
    localparam logic [2:0] REG_ANGLE_P_GAIN    = 3'd0;
    localparam logic [2:0] REG_ANGLE_D_GAIN    = 3'd1;
    localparam logic [2:0] REG_SPEED_P_GAIN    = 3'd2;
    localparam logic [2:0] REG_SPEED_I_GAIN    = 3'd3;
    localparam logic [2:0] REG_SPEED_SCALE     = 3'd4;
    localparam logic [2:0] REG_SPEED_TARGET    = 3'd5;
    localparam logic [2:0] REG_ERROR_LIMIT     = 3'd6;
    localparam logic [2:0] REG_INTEGRAL_LIMIT  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG_P,
        ST_ANG_D,
        ST_SPD_MUL,
        ST_SPD_ERR,
        ST_SPD_PMUL,
        ST_SPD_IMUL,
        ST_SPD_INTG,
        ST_SPD_NEXT,
        ST_RMP_MUL,
        ST_RMP_DIV,
        ST_MIX
    } state_t;

endpackage

// ----- rtl/core/bcpm_mul.sv -----
// Bit-serial signed x unsigned multiplier, one multiplier bit per cycle.
// Depends on bcpm_pkg.
`timescale 1ns / 1ps

module bcpm_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [bcpm_pkg::MUL_A_W-1:0] a,
    input  logic        [bcpm_pkg::MUL_B_W-1:0] b,
    output logic                                done,
    output logic signed [bcpm_pkg::PROD_W-1:0]  product
);
    import bcpm_pkg::*;

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W:0]   hi_reg;
    logic signed [MUL_A_W:0]   sum;
    logic        [MUL_B_W-1:0] lo_reg;
    logic        [MUL_CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    assign sum = hi_reg + (lo_reg[0] ? {a_reg[MUL_A_W-1], a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath: low product bits shift in as multiplier bits retire
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum >>> 1;
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ----- rtl/core/bcpm_div.sv -----
// Bit-serial restoring divider by a fixed divisor, one quotient bit per cycle.
// Depends on bcpm_pkg.
`timescale 1ns / 1ps

module bcpm_div #(
    parameter int DIVISOR = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [bcpm_pkg::DIV_W-1:0] dividend,
    output logic                       done,
    output logic [bcpm_pkg::DIV_W-1:0] quotient
);
    import bcpm_pkg::*;

    localparam int RW = $clog2(DIVISOR + 1);

    logic [DIV_W-1:0]     dvd_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW:0]          trial;
    logic                 ge;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge    = trial >= (RW + 1)'(DIVISOR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? RW'(trial - (RW + 1)'(DIVISOR)) : trial[RW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- rtl/core/balance_cascade_pd_pi_mixer.sv -----
// Top level of the cascaded balance controller: sequencer and datapath.
// Depends on bcpm_pkg, bcpm_mul and bcpm_div.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one control tick per transaction (pitch, gyro rate, both
//   encoder counts, steering term). m_ channel: one transaction per tick
//   with the left and right drive commands.
//   cfg_wr_en / cfg_addr / cfg_wr_data write the gains and limits; write
//   only while no tick is in flight.
// Sequence
//   Every product goes through one shared bit-serial multiplier, and the
//   ramp division through a bit-serial divider. A plain tick runs the two
//   angle products, the ramp product and division, and the mix; a tick that
//   also runs the speed loop adds three products and the error, integral
//   and speed output steps. One tick is in work at a time; the next is
//   accepted in the cycle after the result is loaded.
// Reset
//   aresetn (synchronous, low) restores the register defaults and clears
//   pulse sum, tick count, integral and both speed outputs. s_tready is
//   held low while aresetn is low.
// Stall
//   A finished result waits in the output register; the next tick is still
//   accepted and computed, and holds in its last step until m_tready frees
//   the register.
module balance_cascade_pd_pi_mixer #(
    parameter int SPEED_PERIOD = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pitch[15:0], gyro_rate[31:16], left_count[47:32], right_count[63:48],
    // steer[95:64]
    input  logic [95:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_drive[31:0], right_drive[63:32]
    output logic [63:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);
    import bcpm_pkg::*;

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sd2147483648);

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (x < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [31:0] angle_p_gain_reg, angle_d_gain_reg, speed_p_gain_reg;
    logic [31:0] speed_i_gain_reg, speed_scale_reg;
    logic signed [31:0] speed_target_reg;
    logic [30:0] error_limit_reg, integral_limit_reg;

    // controller state
    logic signed [15:0] pulse_sum_reg;
    logic [5:0]  tick_count_reg;
    logic signed [31:0] speed_integral_reg, speed_out_prev_reg, speed_out_next_reg;

    // per-tick working registers
    logic signed [15:0] pitch_reg, gyro_reg;
    logic signed [31:0] steer_reg;
    logic        run_speed_reg;
    logic signed [33:0] angle_p_reg;
    logic signed [31:0] angle_reg, speed_reg, err_reg, p_reg, i_reg, speed_out_reg;
    logic        ramp_neg_reg;
    logic [DIV_W-1:0] ramp_mag_reg;
    logic [63:0] out_data_reg;
    logic        out_valid_reg;

    state_t state_reg, state_next;

    // serial unit control
    logic mul_start, mul_done, mul_state, mul_run_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_product;
    logic div_start, div_done, div_run_reg;
    logic [DIV_W-1:0] div_quotient;

    logic accept, load_out;

    // rounding taps on the product
    logic signed [PROD_W-1:0] rnd8_w, rnd16_w, rnd24_w;
    logic signed [PROD_W-1:0] prod_mag_w, ramp_w, isum_w, lim_w;
    logic signed [15:0] half_w;
    logic signed [17:0] psum_w;
    logic [32:0] aerr_w;
    logic run_speed_w;

    assign rnd8_w  = (mul_product + PROD_W'(128)) >>> 8;
    assign rnd16_w = (mul_product + PROD_W'(32768)) >>> 16;
    assign rnd24_w = (mul_product + PROD_W'(8388608)) >>> 24;
    assign prod_mag_w = mul_product[PROD_W-1] ? -mul_product : mul_product;
    assign ramp_w  = ramp_neg_reg ? -PROD_W'(div_quotient) : PROD_W'(div_quotient);
    assign half_w  = pulse_sum_reg >>> 1;
    assign aerr_w  = err_reg[31] ? -MUL_A_W'(err_reg) : MUL_A_W'(err_reg);
    assign isum_w  = PROD_W'(sat32(PROD_W'(speed_integral_reg) + PROD_W'(i_reg)));
    assign lim_w   = {{(PROD_W - 31){1'b0}}, integral_limit_reg};
    assign psum_w  = 18'(pulse_sum_reg) + 18'(signed'(s_tdata[47:32]))
                   + 18'(signed'(s_tdata[63:48]));
    assign run_speed_w = tick_count_reg >= 6'(SPEED_PERIOD);

    assign accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_p_gain_reg   <= 32'd1258291;
            angle_d_gain_reg   <= 32'd1342;
            speed_p_gain_reg   <= 32'd1929380;
            speed_i_gain_reg   <= 32'd251658;
            speed_scale_reg    <= 32'd16777216;
            speed_target_reg   <= '0;
            error_limit_reg    <= 31'h7fffffff;
            integral_limit_reg <= 31'h7fffffff;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ANGLE_P_GAIN:   angle_p_gain_reg   <= cfg_wr_data;
                REG_ANGLE_D_GAIN:   angle_d_gain_reg   <= cfg_wr_data;
                REG_SPEED_P_GAIN:   speed_p_gain_reg   <= cfg_wr_data;
                REG_SPEED_I_GAIN:   speed_i_gain_reg   <= cfg_wr_data;
                REG_SPEED_SCALE:    speed_scale_reg    <= cfg_wr_data;
                REG_SPEED_TARGET:   speed_target_reg   <= cfg_wr_data;
                REG_ERROR_LIMIT:    error_limit_reg    <= cfg_wr_data[30:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wr_data[30:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_ANG_P;
            ST_ANG_P:    if (mul_done) state_next = ST_ANG_D;
            ST_ANG_D: begin
                if (mul_done) state_next = run_speed_reg ? ST_SPD_MUL : ST_RMP_MUL;
            end
            ST_SPD_MUL:  if (mul_done) state_next = ST_SPD_ERR;
            ST_SPD_ERR:  state_next = ST_SPD_PMUL;
            ST_SPD_PMUL: if (mul_done) state_next = ST_SPD_IMUL;
            ST_SPD_IMUL: if (mul_done) state_next = ST_SPD_INTG;
            ST_SPD_INTG: state_next = ST_SPD_NEXT;
            ST_SPD_NEXT: state_next = ST_RMP_MUL;
            ST_RMP_MUL:  if (mul_done) state_next = ST_RMP_DIV;
            ST_RMP_DIV:  if (div_done) state_next = ST_MIX;
            ST_MIX:      if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: operand selection and unit launches
    always_comb begin
        s_tready  = 1'b0;
        mul_state = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = aresetn;
            ST_ANG_P: begin
                mul_state = 1'b1;
                mul_a     = MUL_A_W'(pitch_reg);
                mul_b     = angle_p_gain_reg;
            end
            ST_ANG_D: begin
                mul_state = 1'b1;
                mul_a     = MUL_A_W'(gyro_reg);
                mul_b     = angle_d_gain_reg;
            end
            ST_SPD_MUL: begin
                mul_state = 1'b1;
                mul_a     = -MUL_A_W'(half_w);
                mul_b     = speed_scale_reg;
            end
            ST_SPD_PMUL: begin
                mul_state = 1'b1;
                mul_a     = MUL_A_W'(err_reg);
                mul_b     = speed_p_gain_reg;
            end
            ST_SPD_IMUL: begin
                mul_state = 1'b1;
                mul_a     = MUL_A_W'(err_reg);
                mul_b     = speed_i_gain_reg;
            end
            ST_RMP_MUL: begin
                mul_state = 1'b1;
                mul_a     = MUL_A_W'(speed_out_next_reg) - MUL_A_W'(speed_out_prev_reg);
                mul_b     = MUL_B_W'(tick_count_reg);
            end
            ST_RMP_DIV: div_start = !div_run_reg;
            ST_MIX:     load_out  = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign mul_start = mul_state && !mul_run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_run_reg <= 1'b0;
            div_run_reg <= 1'b0;
        end else begin
            if (mul_start) mul_run_reg <= 1'b1;
            else if (mul_done) mul_run_reg <= 1'b0;
            if (div_start) div_run_reg <= 1'b1;
            else if (div_done) div_run_reg <= 1'b0;
        end
    end

    // controller state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_sum_reg      <= '0;
            tick_count_reg     <= '0;
            speed_integral_reg <= '0;
            speed_out_prev_reg <= '0;
            speed_out_next_reg <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                if (psum_w > 18'sd32767) pulse_sum_reg <= 16'sh7fff;
                else if (psum_w < -18'sd32768) pulse_sum_reg <= 16'sh8000;
                else pulse_sum_reg <= psum_w[15:0];
                tick_count_reg <= run_speed_w ? 6'd1 : tick_count_reg + 6'd1;
            end
            if (state_reg == ST_SPD_MUL && mul_done) pulse_sum_reg <= '0;
            if (state_reg == ST_SPD_INTG) begin
                if (isum_w > lim_w) speed_integral_reg <= lim_w[31:0];
                else if (isum_w < -lim_w) speed_integral_reg <= -lim_w[31:0];
                else speed_integral_reg <= isum_w[31:0];
            end
            if (state_reg == ST_SPD_NEXT) begin
                speed_out_prev_reg <= speed_out_next_reg;
                speed_out_next_reg <= sat32(PROD_W'(p_reg) + PROD_W'(speed_integral_reg));
            end
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // per-tick datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            pitch_reg     <= s_tdata[15:0];
            gyro_reg      <= s_tdata[31:16];
            steer_reg     <= s_tdata[95:64];
            run_speed_reg <= run_speed_w;
        end
        if (mul_done) begin
            case (state_reg)
                ST_ANG_P:    angle_p_reg <= rnd16_w[33:0];
                ST_ANG_D:    angle_reg   <= sat32(rnd8_w + PROD_W'(angle_p_reg));
                ST_SPD_MUL:  speed_reg   <= sat32(rnd8_w);
                ST_SPD_PMUL: p_reg       <= sat32(rnd24_w);
                ST_SPD_IMUL: begin
                    // integration skipped on a large speed error
                    i_reg <= (aerr_w > 33'(error_limit_reg)) ? '0 : sat32(rnd24_w);
                end
                ST_RMP_MUL: begin
                    ramp_neg_reg <= mul_product[PROD_W-1];
                    ramp_mag_reg <= prod_mag_w[DIV_W-1:0];
                end
                default: ;
            endcase
        end
        if (state_reg == ST_SPD_ERR) begin
            err_reg <= sat32(PROD_W'(speed_target_reg) - PROD_W'(speed_reg));
        end
        if (state_reg == ST_RMP_DIV && div_done) begin
            speed_out_reg <= sat32(PROD_W'(speed_out_prev_reg) + ramp_w);
        end
        if (load_out) begin
            out_data_reg[31:0]  <= sat32(PROD_W'(angle_reg) - PROD_W'(speed_out_reg)
                                         - PROD_W'(steer_reg));
            out_data_reg[63:32] <= sat32(PROD_W'(angle_reg) - PROD_W'(speed_out_reg)
                                         + PROD_W'(steer_reg));
        end
    end

    bcpm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    bcpm_div #(
        .DIVISOR (SPEED_PERIOD)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ramp_mag_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    // checks
    a_idle_units_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!mul_run_reg && !div_run_reg))
        else $error("serial unit busy while idle");

    a_mul_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> mul_state)
        else $error("multiplier result outside a multiply step");

    a_tick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg <= 6'(SPEED_PERIOD))
        else $error("tick count beyond speed period");

    a_out_from_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_MIX))
        else $error("result raised outside mix step");

endmodule

// ----- sim/balance_cascade_pd_pi_mixer_test.sv -----
// Self-checking bench for balance_cascade_pd_pi_mixer: directed and random ticks against
// a cycle-free predictor of the PD angle term, PI speed loop, speed ramp and drive mix.
// Depends on bcpm_pkg and the block's RTL.
`timescale 1ns / 1ps

module balance_cascade_pd_pi_mixer_test;
    import bcpm_pkg::*;

    localparam int PERIOD     = 16;
    localparam int IDLE_LIMIT = 20000;   // cycles with no transaction on either side
    localparam int HOLD_OFF   = 1500;    // long receiver stall
    localparam int TAIL       = 400;     // > one speed-loop tick

    typedef struct packed {
        logic signed [31:0] steer;
        logic signed [15:0] rcnt;
        logic signed [15:0] lcnt;
        logic signed [15:0] gyro;
        logic signed [15:0] pitch;
    } tick_t;

    typedef struct {
        int left_drv;
        int right_drv;
    } drive_t;

    logic        aclk;
    logic        aresetn;
    logic [95:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    balance_cascade_pd_pi_mixer #(.SPEED_PERIOD(PERIOD)) dut (.*);

    // predictor copy of the registers and state
    logic [31:0] ang_p, ang_d, spd_p, spd_i, spd_scale, err_lim, int_lim;
    int          spd_target;
    int          psum, tick_cnt, integ, out_prev, out_next;

    tick_t  pending_ticks[$];
    drive_t expected_drives[$];
    tick_t  cur_tick;
    int     send_gap, recv_gap, n_sent, mismatches, idle_cycles;
    bit     no_gaps, hold_rx;

    function automatic int sat32(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return int'(x);
    endfunction

    // add half an LSB, then floor shift
    function automatic longint rnd_shr(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void run_speed_loop();
        longint half, lim, aerr;
        int spd, err, p, i;
        half = longint'(psum) >>> 1;
        spd  = sat32(rnd_shr(-half * longint'({32'b0, spd_scale}), 8));
        psum = 0;
        err  = sat32(longint'(spd_target) - longint'(spd));
        p    = sat32(rnd_shr(longint'(err) * longint'({32'b0, spd_p}), 24));
        i    = sat32(rnd_shr(longint'(err) * longint'({32'b0, spd_i}), 24));
        aerr = err < 0 ? -longint'(err) : longint'(err);
        if (aerr > longint'({33'b0, err_lim[30:0]})) i = 0;
        lim   = longint'({33'b0, int_lim[30:0]});
        integ = sat32(longint'(integ) + longint'(i));
        if (integ > lim) integ = int'(lim);
        if (integ < -lim) integ = int'(-lim);
        out_prev = out_next;
        out_next = sat32(longint'(p) + longint'(integ));
    endfunction

    function automatic drive_t predict_drive(tick_t t);
        drive_t d;
        int angle, spd_out;
        longint ramp, s;
        angle = sat32(rnd_shr(longint'(t.pitch) * longint'({32'b0, ang_p}), 16) +
                      rnd_shr(longint'(t.gyro) * longint'({32'b0, ang_d}), 8));
        s = longint'(psum) + longint'(t.lcnt) + longint'(t.rcnt);
        psum = s > 32767 ? 32767 : (s < -32768 ? -32768 : int'(s));
        if (tick_cnt >= PERIOD) begin
            run_speed_loop();
            tick_cnt = 0;
        end
        tick_cnt = (tick_cnt + 1) & 63;
        ramp = (longint'(out_next) - longint'(out_prev)) * tick_cnt / PERIOD;
        spd_out = sat32(longint'(out_prev) + ramp);
        s = longint'(t.steer);
        d.left_drv  = sat32(longint'(angle) - spd_out - s);
        d.right_drv = sat32(longint'(angle) - spd_out + s);
        return d;
    endfunction

    // mostly short gaps, a few long ones, half the time none
    function automatic int pick_gap();
        if (no_gaps || $urandom_range(1, 0)) return 0;
        if ($urandom_range(19, 0) == 0) return $urandom_range(300, 20);
        return $urandom_range(3, 1);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // sender: holds a transaction until taken, predicts it on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                expected_drives.push_back(predict_drive(cur_tick));
                n_sent++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                cur_tick = pending_ticks.pop_front();
                s_tdata  <= cur_tick;
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: compare each result with the oldest expectation
    always @(posedge aclk) begin
        drive_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    want = expected_drives.pop_front();
                    if (m_tdata[31:0] !== want.left_drv || m_tdata[63:32] !== want.right_drv) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive mismatch: left exp %h got %h, right exp %h got %h",
                                     want.left_drv, m_tdata[31:0], want.right_drv,
                                     m_tdata[63:32]);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !hold_rx;
                if (m_tvalid && m_tready) recv_gap = pick_gap();
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long receiver hold-off once traffic is flowing, so the input backs up
    initial begin
        hold_rx = 1'b0;
        wait (n_sent >= 150);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_OFF) @(posedge aclk);
        hold_rx = 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_ANGLE_P_GAIN:   ang_p = val;
            REG_ANGLE_D_GAIN:   ang_d = val;
            REG_SPEED_P_GAIN:   spd_p = val;
            REG_SPEED_I_GAIN:   spd_i = val;
            REG_SPEED_SCALE:    spd_scale = val;
            REG_SPEED_TARGET:   spd_target = val;
            REG_ERROR_LIMIT:    err_lim = {1'b0, val[30:0]};
            REG_INTEGRAL_LIMIT: int_lim = {1'b0, val[30:0]};
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_reg(logic [31:0] dflt);
        case ($urandom_range(5, 0))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return dflt;
            3: return $urandom_range(32'h00200000, 0);
            default: return $urandom();
        endcase
    endfunction

    // random content; small values most of the time so the loop stays in range
    function automatic tick_t rand_tick();
        tick_t t;
        t = {$urandom(), $urandom(), $urandom()};
        if ($urandom_range(3, 0) != 0) begin
            t.pitch = $signed(16'($urandom_range(2000, 0))) - 16'sd1000;
            t.gyro  = $signed(16'($urandom_range(4000, 0))) - 16'sd2000;
            t.lcnt  = $signed(16'($urandom_range(60, 0))) - 16'sd30;
            t.rcnt  = $signed(16'($urandom_range(60, 0))) - 16'sd30;
            t.steer = $signed(32'($urandom_range(32'h40000, 0))) - 32'sh20000;
        end
        return t;
    endfunction

    task automatic settle();
        wait (pending_ticks.size() == 0 && !s_tvalid && expected_drives.size() == 0);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic push_tick(int p, int g, int l, int r, int st);
        tick_t t;
        t.pitch = 16'(p); t.gyro = 16'(g); t.lcnt = 16'(l); t.rcnt = 16'(r); t.steer = st;
        pending_ticks.push_back(t);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_wr_en = 1'b0; cfg_addr = REG_ANGLE_P_GAIN; cfg_wr_data = '0;
        send_gap = 0; recv_gap = 0; n_sent = 0; mismatches = 0; idle_cycles = 0;
        no_gaps = 1'b0;
        ang_p = 32'd1258291; ang_d = 32'd1342; spd_p = 32'd1929380; spd_i = 32'd251658;
        spd_scale = 32'd16777216; spd_target = 0;
        err_lim = 32'h7fffffff; int_lim = 32'h7fffffff;
        psum = 0; tick_cnt = 0; integ = 0; out_prev = 0; out_next = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset defaults first, then field extremes
        push_tick(0, 0, 0, 0, 0);
        push_tick(32767, 32767, 32767, 32767, 32'h7fffffff);     // pulse sum saturates high
        push_tick(-32768, -32768, -32768, -32768, 32'h80000000); // and low
        push_tick(32767, -32768, 100, -100, 32'h80000000);
        push_tick(-32768, 32767, -1, -1, 32'h7fffffff);
        for (int k = 0; k < 14; k++) push_tick(k * 97, -k * 31, 5, 3, k * 4096);
        push_tick(-1, -1, -3, 0, -1);                            // odd negative count sum
        settle();

        // several settings; extremes on gains, scale, target and both limits
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_ANGLE_P_GAIN,   ph == 1 ? 32'hffffffff : pick_reg(32'd1258291));
            write_reg(REG_ANGLE_D_GAIN,   ph == 1 ? 32'hffffffff : pick_reg(32'd1342));
            write_reg(REG_SPEED_P_GAIN,   ph == 1 ? 32'hffffffff : pick_reg(32'd1929380));
            write_reg(REG_SPEED_I_GAIN,   ph == 1 ? 32'hffffffff : pick_reg(32'd251658));
            write_reg(REG_SPEED_SCALE,    ph == 1 ? 32'hffffffff : pick_reg(32'd16777216));
            write_reg(REG_SPEED_TARGET,   ph == 2 ? 32'h80000000 :
                                          ph == 1 ? 32'h7fffffff : pick_reg(32'h0));
            write_reg(REG_ERROR_LIMIT,    ph == 2 ? 32'h0 : ph == 3 ? 32'h00030000 :
                                          pick_reg(32'h7fffffff));
            write_reg(REG_INTEGRAL_LIMIT, ph == 2 ? 32'h0 : ph == 4 ? 32'h00008000 :
                                          pick_reg(32'h7fffffff));
            no_gaps = (ph == 5);
            for (int k = 0; k < 100; k++) pending_ticks.push_back(rand_tick());
            settle();
        end

        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
